/* rtl/tbsr_pkg.sv */
`timescale 1ns / 1ps

package tbsr_pkg;

    localparam int unsigned SLOT_COUNT      = 3;
    localparam int unsigned WORDS_PER_IMAGE = 9;
    localparam int unsigned BYTES_PER_IMAGE = 2 * WORDS_PER_IMAGE;

    localparam logic [2:0] MODE_UPDATE     = 3'd0;
    localparam logic [2:0] MODE_SET_ADDR   = 3'd1;
    localparam logic [2:0] MODE_READ_START = 3'd2;
    localparam logic [2:0] MODE_READ_NEXT  = 3'd3;
    localparam logic [2:0] MODE_STOP       = 3'd4;

    localparam logic [1:0] WRITER_RESET  = 2'd1;
    localparam logic [1:0] PENDING_RESET = 2'd2;
    localparam logic [1:0] READER_RESET  = 2'd0;

    localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;
    localparam logic [7:0] IDLE_BYTE     = 8'h00;

    localparam logic [7:0] GYRO_FIRST  = 8'h14;
    localparam logic [7:0] EULER_LAST  = 8'h1F;
    localparam logic [7:0] ACCEL_FIRST = 8'h28;
    localparam logic [7:0] ACCEL_LAST  = 8'h2D;
    localparam logic [4:0] ACCEL_BASE  = 5'd12;

    typedef logic [BYTES_PER_IMAGE-1:0][7:0] t_row;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SERVE = 2'b10
    } t_state;

endpackage

/* rtl/triple_buffered_sensor_register_target.sv */
`timescale 1ns / 1ps

// Every transaction accepted on start (while busy is low) yields exactly one result, shown on
// o_read_byte and o_byte_valid for the single cycle in which o_strobe is high. At the edge that
// accepts a transaction the slot roles and the register pointer are updated, an update writes
// its whole image as one row of the three-row image memory, and a read issues the row read of
// its image; busy is then high for one cycle while the registered row data is turned into the
// served byte, and the result appears in the cycle after that. As the memory read is registered,
// start is not accepted while busy is high, but can be in the cycle in which a result is shown.
// Results cannot be held off and must be taken in the cycle they are shown. Reset needs no
// clearing pass: each image row has a valid flag, and a row never written reads as zeros.
module triple_buffered_sensor_register_target (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_register_address,
    input  logic [15:0] i_gyro_x,
    input  logic [15:0] i_gyro_y,
    input  logic [15:0] i_gyro_z,
    input  logic [15:0] i_euler_x,
    input  logic [15:0] i_euler_y,
    input  logic [15:0] i_euler_z,
    input  logic [15:0] i_accel_x,
    input  logic [15:0] i_accel_y,
    input  logic [15:0] i_accel_z,
    output logic        o_strobe,
    output logic [7:0]  o_read_byte,
    output logic        o_byte_valid
);

    tbsr_pkg::t_row r_image_mem [tbsr_pkg::SLOT_COUNT];
    tbsr_pkg::t_row r_rd_row;

    tbsr_pkg::t_state r_state, n_state;

    logic [tbsr_pkg::SLOT_COUNT-1:0] r_row_valid;
    logic [1:0] r_writer, n_writer;
    logic [1:0] r_pending, n_pending;
    logic [1:0] r_reader, n_reader;
    logic [7:0] r_pointer, n_pointer;

    logic       r_is_read;
    logic       r_mapped;
    logic       r_rd_row_valid;
    logic [4:0] r_offset;

    logic       r_strobe;
    logic [7:0] r_read_byte;
    logic       r_byte_valid;

    logic       accept;
    logic       is_read;
    logic       do_write;
    logic [1:0] rd_slot;
    logic       rd_slot_ok;
    logic       mapped;
    logic [4:0] offset;
    logic [7:0] gyro_delta;
    logic [7:0] accel_delta;
    tbsr_pkg::t_row wr_row;

    assign accept = start && (r_state == tbsr_pkg::ST_IDLE);
    assign busy   = (r_state == tbsr_pkg::ST_SERVE);

    assign wr_row = {i_accel_z, i_accel_y, i_accel_x,
                     i_euler_z, i_euler_y, i_euler_x,
                     i_gyro_z, i_gyro_y, i_gyro_x};

    assign gyro_delta  = r_pointer - tbsr_pkg::GYRO_FIRST;
    assign accel_delta = r_pointer - tbsr_pkg::ACCEL_FIRST;

    always_comb begin
        n_writer  = r_writer;
        n_pending = r_pending;
        n_reader  = r_reader;
        n_pointer = r_pointer;
        is_read   = 1'b0;
        do_write  = 1'b0;
        rd_slot   = r_reader;
        unique case (i_mode)
            tbsr_pkg::MODE_UPDATE: begin
                do_write  = (r_writer < 2'(tbsr_pkg::SLOT_COUNT));
                n_writer  = r_pending;
                n_pending = r_writer;
            end
            tbsr_pkg::MODE_SET_ADDR: begin
                n_pointer = i_register_address;
            end
            tbsr_pkg::MODE_READ_START: begin
                n_reader  = r_pending;
                n_pending = r_reader;
                rd_slot   = r_pending;
                is_read   = 1'b1;
                n_pointer = r_pointer + 8'd1;
            end
            tbsr_pkg::MODE_READ_NEXT: begin
                is_read   = 1'b1;
                n_pointer = r_pointer + 8'd1;
            end
            tbsr_pkg::MODE_STOP: begin
                n_pointer = 8'd0;
            end
            default: begin
            end
        endcase
    end

    assign rd_slot_ok = (rd_slot < 2'(tbsr_pkg::SLOT_COUNT));

    always_comb begin
        mapped = 1'b0;
        offset = 5'd0;
        if (r_pointer >= tbsr_pkg::GYRO_FIRST && r_pointer <= tbsr_pkg::EULER_LAST) begin
            mapped = 1'b1;
            offset = gyro_delta[4:0];
        end else if (r_pointer >= tbsr_pkg::ACCEL_FIRST
                     && r_pointer <= tbsr_pkg::ACCEL_LAST) begin
            mapped = 1'b1;
            offset = tbsr_pkg::ACCEL_BASE + accel_delta[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && do_write) begin
            r_image_mem[r_writer] <= wr_row;
        end
        if (accept && is_read && rd_slot_ok) begin
            r_rd_row <= r_image_mem[rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_read      <= is_read;
            r_mapped       <= mapped && rd_slot_ok;
            r_offset       <= offset;
            r_rd_row_valid <= rd_slot_ok && r_row_valid[rd_slot];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tbsr_pkg::ST_IDLE:  if (accept) n_state = tbsr_pkg::ST_SERVE;
            tbsr_pkg::ST_SERVE: n_state = tbsr_pkg::ST_IDLE;
            default:            n_state = tbsr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tbsr_pkg::ST_IDLE;
            r_row_valid <= '0;
            r_writer    <= tbsr_pkg::WRITER_RESET;
            r_pending   <= tbsr_pkg::PENDING_RESET;
            r_reader    <= tbsr_pkg::READER_RESET;
            r_pointer   <= 8'd0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_writer  <= n_writer;
                r_pending <= n_pending;
                r_reader  <= n_reader;
                r_pointer <= n_pointer;
                if (do_write) begin
                    r_row_valid[r_writer] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe     <= 1'b0;
            r_byte_valid <= 1'b0;
            r_read_byte  <= tbsr_pkg::IDLE_BYTE;
        end else if (r_state == tbsr_pkg::ST_SERVE) begin
            r_strobe     <= 1'b1;
            r_byte_valid <= r_is_read;
            if (!r_is_read) begin
                r_read_byte <= tbsr_pkg::IDLE_BYTE;
            end else if (!r_mapped) begin
                r_read_byte <= tbsr_pkg::UNMAPPED_BYTE;
            end else if (!r_rd_row_valid) begin
                r_read_byte <= 8'd0;
            end else begin
                r_read_byte <= r_rd_row[r_offset];
            end
        end else begin
            r_strobe     <= 1'b0;
            r_byte_valid <= 1'b0;
            r_read_byte  <= tbsr_pkg::IDLE_BYTE;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_read_byte  = r_read_byte;
    assign o_byte_valid = r_byte_valid;

endmodule

/* rtl/tbsr_checker.sv */
`timescale 1ns / 1ps

module tbsr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic [7:0] o_read_byte,
    input logic       o_byte_valid
);

    // An accepted transaction raises busy, which holds off the next one.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted transaction");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy stayed high for more than one cycle");

    // Each transaction yields one result right after its busy cycle, and no other results.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_strobe)
        else $error("result missing after a busy cycle");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !o_strobe)
        else $error("result strobe without a transaction");

    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_byte_valid |-> (o_read_byte == 8'h00))
        else $error("read byte nonzero without a served byte");

endmodule

bind triple_buffered_sensor_register_target tbsr_checker u_tbsr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_read_byte  (o_read_byte),
    .o_byte_valid (o_byte_valid)
);
